### rtl/infix_expression_evaluator_unit_assert.svh
// Assertion macros for the infix expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Implication checked on every edge out of reset
`define IEE_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked out of reset
`define IEE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Types, codes and sizes shared by the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int VALUE_DEPTH    = 32;
    localparam int OPERATOR_DEPTH = 32;
    localparam int WORD_WIDTH     = 32;
    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam int WCW = $clog2(WORD_WIDTH + 1);

    // token kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_EOL   = 2'd2;

    // operator codes
    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_CLOSE = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_REM   = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_PAREN    = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OP,
        S_DECIDE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV_WAIT,
        S_FINAL_RD,
        S_FINAL,
        S_OUT
    } state_t;

    // what the current token does once the operator stack top is known
    typedef enum logic [1:0] {
        TASK_OP_ADD_CLASS,
        TASK_OP_MUL_CLASS,
        TASK_OP_CLOSE,
        TASK_EOL
    } task_t;

    typedef struct packed {
        logic                  start;
        logic                  is_rem;
        logic [WORD_WIDTH-1:0] a;
        logic [WORD_WIDTH-1:0] b;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [WORD_WIDTH-1:0] value;
    } div_rsp_t;

endpackage

### rtl/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/iee_divider.sv
// ----------------------------------------------------------------------------
// iee_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module iee_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  iee_pkg::div_req_t req,
    output iee_pkg::div_rsp_t rsp
);
    import iee_pkg::*;

    logic                  busy_reg, busy_next;
    logic [WCW-1:0]        cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] quo_reg, quo_next;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [WORD_WIDTH-1:0] den_reg, den_next;
    logic                  nq_reg, nq_next;
    logic                  nr_reg, nr_next;
    logic                  isr_reg, isr_next;
    logic                  done_reg, done_next;
    logic [WORD_WIDTH:0]   trial;
    logic [WORD_WIDTH-1:0] mag_a, mag_b, fin;

    always_comb
    begin
        mag_a = req.a[WORD_WIDTH-1] ? (~req.a + 1'b1) : req.a;
        mag_b = req.b[WORD_WIDTH-1] ? (~req.b + 1'b1) : req.b;
        trial = {rem_reg, quo_reg[WORD_WIDTH-1]} - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        isr_next  = isr_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = WCW'(WORD_WIDTH);
            quo_next  = mag_a;
            rem_next  = '0;
            den_next  = mag_b;
            nq_next   = req.a[WORD_WIDTH-1] ^ req.b[WORD_WIDTH-1];
            nr_next   = req.a[WORD_WIDTH-1];
            isr_next  = req.is_rem;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract if it fits
            if (!trial[WORD_WIDTH])
            begin
                rem_next = trial[WORD_WIDTH-1:0];
                quo_next = {quo_reg[WORD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WORD_WIDTH-2:0], quo_reg[WORD_WIDTH-1]};
                quo_next = {quo_reg[WORD_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == WCW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
        isr_reg <= isr_next;
    end

    // sign fixup of the finished quotient or remainder
    always_comb
    begin
        if (isr_reg)
        begin
            fin = nr_reg ? (~rem_reg + 1'b1) : rem_reg;
        end
        else
        begin
            fin = nq_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = fin;

endmodule

### rtl/infix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Two-stack infix integer evaluator for a stream of tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries tokens: tdata = {op_code, number}, tuser = kind.
//   Values and operators are absorbed; an end-of-line token produces one
//   item on m_axis with tdata = {status, result}.
//   Both stacks live in RAMs with registered reads.
//   One token is processed at a time. A value is handled when taken. An
//   operator reads the operator stack top; each reduction it triggers reads
//   both values, executes and writes back, and a divide or remainder
//   reduction waits on the bit-serial divider, which sets the worst case.
//   End of line reduces the rest and does the final read before the output.
//   The result sits in an output register; while the receiver stalls,
//   s_axis_tready stays low until the item is taken.
//   Reset clears counts, error code and control state; stack contents are
//   not cleared because entries are only read below the count.
//   The first error is sticky for the rest of the line.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] number, [34:32] op_code
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [31:0] result, [34:32] status
);
    import iee_pkg::*;

    state_t                state_reg, state_next;
    task_t                 task_reg, task_next;
    logic [VCW-1:0]        vc_reg, vc_next;
    logic [OCW-1:0]        oc_reg, oc_next;
    logic [2:0]            err_reg, err_next;
    logic [2:0]            newop_reg, newop_next;
    logic [2:0]            top_reg, top_next;
    logic [WORD_WIDTH-1:0] b_reg, b_next;
    logic [WORD_WIDTH-1:0] a_reg, a_next;
    logic [WORD_WIDTH-1:0] res_reg, res_next;
    logic [2:0]            st_reg, st_next;
    logic                  ov_reg, ov_next;

    logic                  vwe, owe;
    logic [VAW-1:0]        vwaddr, vraddr;
    logic [OAW-1:0]        owaddr, oraddr;
    logic [WORD_WIDTH-1:0] vwdata, vrdata;
    logic [2:0]            owdata, ordata;
    logic [WORD_WIDTH-1:0] prod;
    div_req_t              dreq;
    div_rsp_t              drsp;
    logic                  accept;
    logic [WORD_WIDTH-1:0] in_num;

    iee_ram #(.WIDTH(WORD_WIDTH), .DEPTH(VALUE_DEPTH)) u_value_ram (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
        .raddr(vraddr), .rdata(vrdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_op_ram (
        .clk(clk), .we(owe), .waddr(owaddr), .wdata(owdata),
        .raddr(oraddr), .rdata(ordata)
    );

    iee_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_num        = WORD_WIDTH'($signed(s_axis_tdata[31:0]));
    assign prod          = a_reg * b_reg;

    always_comb
    begin
        state_next = state_reg;
        task_next  = task_reg;
        vc_next    = vc_reg;
        oc_next    = oc_reg;
        err_next   = err_reg;
        newop_next = newop_reg;
        top_next   = top_reg;
        b_next     = b_reg;
        a_next     = a_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        vwe        = 1'b0;
        owe        = 1'b0;
        vwaddr     = VAW'(vc_reg);
        vwdata     = in_num;
        owaddr     = OAW'(oc_reg);
        owdata     = newop_reg;
        vraddr     = VAW'(vc_reg - 1'b1);
        oraddr     = OAW'(oc_reg - 1'b1);
        dreq.start  = 1'b0;
        dreq.is_rem = (top_reg == OP_REM);
        dreq.a      = a_reg;
        dreq.b      = b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    newop_next = s_axis_tdata[34:32];
                    case (s_axis_tuser)
                        KIND_VALUE:
                        begin
                            // push value unless an error is pending
                            if (err_reg == ST_OK)
                            begin
                                if (vc_reg >= VCW'(VALUE_DEPTH))
                                begin
                                    err_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    vwe     = 1'b1;
                                    vc_next = vc_reg + 1'b1;
                                end
                            end
                        end
                        KIND_OP:
                        begin
                            if (err_reg == ST_OK)
                            begin
                                case (s_axis_tdata[34:32])
                                    OP_OPEN:
                                    begin
                                        if (oc_reg >= OCW'(OPERATOR_DEPTH))
                                        begin
                                            err_next = ST_OVERFLOW;
                                        end
                                        else
                                        begin
                                            owe     = 1'b1;
                                            owdata  = OP_OPEN;
                                            oc_next = oc_reg + 1'b1;
                                        end
                                    end
                                    OP_CLOSE:
                                    begin
                                        task_next  = TASK_OP_CLOSE;
                                        state_next = S_RD_OP;
                                    end
                                    OP_ADD, OP_SUB:
                                    begin
                                        task_next  = TASK_OP_ADD_CLASS;
                                        state_next = S_RD_OP;
                                    end
                                    OP_MUL, OP_DIV, OP_REM:
                                    begin
                                        task_next  = TASK_OP_MUL_CLASS;
                                        state_next = S_RD_OP;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        KIND_EOL:
                        begin
                            task_next  = TASK_EOL;
                            state_next = S_RD_OP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // read the top operator (address issued in this state)
            S_RD_OP:
            begin
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                top_next   = ordata;
                state_next = S_IDLE;
                if (err_reg != ST_OK)
                begin
                    if (task_reg == TASK_EOL)
                    begin
                        state_next = S_FINAL;
                    end
                end
                else
                begin
                    case (task_reg)
                        TASK_OP_ADD_CLASS, TASK_OP_MUL_CLASS:
                        begin
                            if (oc_reg != '0 && ordata >= OP_ADD && ordata <= OP_REM
                                && (task_reg == TASK_OP_ADD_CLASS || ordata >= OP_MUL))
                            begin
                                state_next = S_RD_B;
                            end
                            else if (oc_reg >= OCW'(OPERATOR_DEPTH))
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                owe     = 1'b1;
                                oc_next = oc_reg + 1'b1;
                            end
                        end
                        TASK_OP_CLOSE:
                        begin
                            if (oc_reg == '0)
                            begin
                                err_next = ST_PAREN;
                            end
                            else if (ordata == OP_OPEN)
                            begin
                                oc_next = oc_reg - 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD_B;
                            end
                        end
                        default:
                        begin
                            // end of line
                            if (oc_reg == '0)
                            begin
                                state_next = S_FINAL_RD;
                            end
                            else if (ordata == OP_OPEN)
                            begin
                                err_next   = ST_PAREN;
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                state_next = S_RD_B;
                            end
                        end
                    endcase
                end
                // reduction needs two values
                if (state_next == S_RD_B && vc_reg < VCW'(2))
                begin
                    err_next   = ST_INVALID;
                    state_next = (task_reg == TASK_EOL) ? S_FINAL : S_IDLE;
                end
            end

            // top value address issued here
            S_RD_B:
            begin
                vraddr     = VAW'(vc_reg - 1'b1);
                state_next = S_RD_A;
            end

            S_RD_A:
            begin
                b_next     = vrdata;
                vraddr     = VAW'(vc_reg - VCW'(2));
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                a_next  = vrdata;
                oc_next = oc_reg - 1'b1;
                vc_next = vc_reg - VCW'(2);
                if (top_reg == OP_DIV || top_reg == OP_REM)
                begin
                    if (b_reg == '0)
                    begin
                        err_next   = ST_DIVZERO;
                        state_next = (task_reg == TASK_EOL) ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.a     = vrdata;
                        state_next = S_DIV_WAIT;
                    end
                end
                else
                begin
                    // add, sub, mul are written back in the next state from a_reg and b_reg
                    state_next = S_DIV_WAIT;
                end
            end

            // write the reduction result, then look at the new top
            S_DIV_WAIT:
            begin
                if (top_reg == OP_DIV || top_reg == OP_REM)
                begin
                    vwdata = drsp.value;
                end
                else if (top_reg == OP_ADD)
                begin
                    vwdata = a_reg + b_reg;
                end
                else if (top_reg == OP_SUB)
                begin
                    vwdata = a_reg - b_reg;
                end
                else
                begin
                    vwdata = prod;
                end
                if (drsp.done || !(top_reg == OP_DIV || top_reg == OP_REM))
                begin
                    vwe        = 1'b1;
                    vwaddr     = VAW'(vc_reg);
                    vc_next    = vc_reg + 1'b1;
                    state_next = S_RD_OP;
                end
            end

            // final read of the bottom entry
            S_FINAL_RD:
            begin
                vraddr     = '0;
                state_next = S_FINAL;
                if (vc_reg != VCW'(1))
                begin
                    err_next = ST_INVALID;
                end
            end

            S_FINAL:
            begin
                st_next    = err_reg;
                res_next   = (err_reg == ST_OK) ? vrdata : '0;
                vc_next    = '0;
                oc_next    = '0;
                err_next   = ST_OK;
                ov_next    = 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            task_reg  <= TASK_EOL;
            vc_reg    <= '0;
            oc_reg    <= '0;
            err_reg   <= ST_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            task_reg  <= task_next;
            vc_reg    <= vc_next;
            oc_reg    <= oc_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newop_reg <= newop_next;
        top_reg   <= top_next;
        b_reg     <= b_next;
        a_reg     <= a_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {5'd0, st_reg, 32'($signed(res_reg))};

endmodule

### rtl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_unit_assert.svh"

module iee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import iee_pkg::*;

    logic [2:0]  out_status;
    logic [31:0] out_value;
    logic        in_accept;

    assign out_status = m_axis_tdata[34:32];
    assign out_value  = m_axis_tdata[31:0];
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // result is zero whenever an error status is reported
    `IEE_ASSERT_IMPL(a_err_zero, clk, rst_n, m_axis_tvalid && out_status != ST_OK, out_value == '0)
    // status code stays in its range
    `IEE_ASSERT_IMPL(a_status_range, clk, rst_n, m_axis_tvalid, out_status <= ST_OVERFLOW)
    // no token is taken while a result is pending
    `IEE_ASSERT_IMPL(a_no_accept_pending, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    // a value token is absorbed without producing an item
    `IEE_ASSERT_NEXT(a_value_silent, clk, rst_n, in_accept && s_axis_tuser == KIND_VALUE, !m_axis_tvalid)

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Token-stream test of the infix expression evaluator: directed lines cover
// precedence, parentheses, division corners and all errors but overflow (its
// own test); random lines are mostly well-formed expressions. A predictor with
// two stacks computes each end-of-line result; a checker compares it in order.
// ----------------------------------------------------------------------------
module tb_top;
    import iee_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [31:0] number, [34:32] op_code
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] result, [34:32] status

    infix_expression_evaluator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result;
    } line_result_t;

    // predictor state
    logic [31:0]  calc_values [VALUE_DEPTH];
    logic [2:0]   calc_ops [OPERATOR_DEPTH];
    int           calc_vcnt;
    int           calc_ocnt;
    logic [2:0]   calc_err;

    line_result_t pending_results [$];
    int           error_count;
    int           line_count;
    int           token_count;
    int           idle_pct;
    int           stall_pct;
    bit           hold_off;
    int           quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void calc_fail(logic [2:0] code);
        if (calc_err == ST_OK)
            calc_err = code;
    endfunction

    function automatic void calc_push_value(logic [31:0] v);
        if (calc_vcnt >= VALUE_DEPTH)
            calc_fail(ST_OVERFLOW);
        else
        begin
            calc_values[calc_vcnt] = v;
            calc_vcnt++;
        end
    endfunction

    function automatic void calc_push_op(logic [2:0] op);
        if (calc_ocnt >= OPERATOR_DEPTH)
            calc_fail(ST_OVERFLOW);
        else
        begin
            calc_ops[calc_ocnt] = op;
            calc_ocnt++;
        end
    endfunction

    function automatic void calc_reduce();
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] ma;
        logic [31:0] mb;
        op = calc_ops[calc_ocnt - 1];
        if (op == OP_OPEN)
        begin
            calc_fail(ST_PAREN);
            return;
        end
        if (calc_vcnt < 2)
        begin
            calc_fail(ST_INVALID);
            return;
        end
        calc_ocnt--;
        b = calc_values[calc_vcnt - 1];
        a = calc_values[calc_vcnt - 2];
        calc_vcnt -= 2;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_REM:
            begin
                if (mb == 0)
                begin
                    calc_fail(ST_DIVZERO);
                    return;
                end
                if (op == OP_DIV)
                begin
                    r = ma / mb;
                    if (a[31] != b[31])
                        r = -r;
                end
                else
                begin
                    r = ma % mb;
                    if (a[31])
                        r = -r;
                end
            end
            default:
            begin
                calc_fail(ST_INVALID);
                return;
            end
        endcase
        calc_push_value(r);
    endfunction

    function automatic bit top_binds_tighter(bit mul_class_only);
        logic [2:0] t;
        if (calc_ocnt == 0)
            return 1'b0;
        t = calc_ops[calc_ocnt - 1];
        if (mul_class_only)
            return t == OP_MUL || t == OP_DIV || t == OP_REM;
        return t >= OP_ADD && t <= OP_REM;
    endfunction

    // applies one token; returns 1 and the expected line result at end of line
    function automatic bit calc_token(logic [1:0] kind, logic [31:0] num,
                                      logic [2:0] op, output line_result_t res);
        res = '0;
        if (kind == KIND_VALUE)
        begin
            if (calc_err == ST_OK)
                calc_push_value(num);
            return 1'b0;
        end
        if (kind == KIND_OP)
        begin
            if (calc_err != ST_OK)
                return 1'b0;
            case (op)
                OP_OPEN: calc_push_op(op);
                OP_CLOSE:
                begin
                    while (calc_err == ST_OK && calc_ocnt != 0
                           && calc_ops[calc_ocnt - 1] != OP_OPEN)
                        calc_reduce();
                    if (calc_err == ST_OK)
                    begin
                        if (calc_ocnt == 0)
                            calc_fail(ST_PAREN);
                        else
                            calc_ocnt--;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM:
                begin
                    while (calc_err == ST_OK && top_binds_tighter(op >= OP_MUL))
                        calc_reduce();
                    if (calc_err == ST_OK)
                        calc_push_op(op);
                end
                default: ;
            endcase
            return 1'b0;
        end
        if (kind != KIND_EOL)
            return 1'b0;
        while (calc_err == ST_OK && calc_ocnt != 0)
            calc_reduce();
        if (calc_err == ST_OK && calc_vcnt != 1)
            calc_fail(ST_INVALID);
        res.status = calc_err;
        res.result = (calc_err == ST_OK) ? calc_values[0] : 32'd0;
        calc_vcnt = 0;
        calc_ocnt = 0;
        calc_err  = ST_OK;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    // tvalid stays high between back-to-back items; it drops only while idling or draining
    task automatic send_token(logic [1:0] kind, logic [31:0] num, logic [2:0] op);
        line_result_t res;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, op, num};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // accepted at this edge
        if (calc_token(kind, num, op, res))
        begin
            pending_results.push_back(res);
            line_count++;
        end
        token_count++;
    endtask

    task automatic send_value(logic [31:0] v);
        send_token(KIND_VALUE, v, 3'($urandom));
    endtask

    task automatic send_op(logic [2:0] op);
        send_token(KIND_OP, $urandom, op);
    endtask

    task automatic send_eol();
        send_token(KIND_EOL, $urandom, 3'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[34:0];
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", 32'(got), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.result != want.result)
                    report_mismatch("result", got.result, want.result);
            end
        end
    end

    // receiver stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_number();
        case ($urandom_range(5))
            0: return $urandom_range(9);
            1: return -$urandom_range(9);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // well-formed expression with random depth; near-zero values make
    // divide-by-zero show up now and then
    task automatic send_expr(int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++)
        begin
            if (i != 0)
                send_op(3'($urandom_range(OP_ADD, OP_REM)));
            if (depth > 0 && $urandom_range(3) == 0)
            begin
                send_op(OP_OPEN);
                send_expr(depth - 1);
                send_op(OP_CLOSE);
            end
            else
                send_value(($urandom_range(3) == 0) ? rand_number()
                                                    : 32'($urandom_range(7)) - 32'd2);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // 2 + 3 * 4
        send_value(2); send_op(OP_ADD); send_value(3); send_op(OP_MUL);
        send_value(4); send_eol();
        // (7 - 9) % -3, then -7 / 2
        send_op(OP_OPEN); send_value(7); send_op(OP_SUB); send_value(9);
        send_op(OP_CLOSE); send_op(OP_REM); send_value(-3); send_eol();
        send_value(-7); send_op(OP_DIV); send_value(2); send_eol();
        // most negative over minus one, both ways
        send_value(32'h8000_0000); send_op(OP_DIV); send_value(-1); send_eol();
        send_value(32'h8000_0000); send_op(OP_REM); send_value(-1); send_eol();
        // divide by zero, blank line, missing operand
        send_value(32'h7fff_ffff); send_op(OP_DIV); send_value(0); send_eol();
        send_eol();
        send_op(OP_ADD); send_value(1); send_eol();
        // stray close and stray open
        send_value(1); send_op(OP_CLOSE); send_eol();
        send_op(OP_OPEN); send_value(1); send_eol();
        // unknown kind and unknown op are ignored
        send_value(5); send_token(2'd3, 32'd1, OP_ADD); send_op(3'd7); send_eol();
        wait_drained();
    endtask

    task automatic test_overflow();
        // value stack full, then operator stack full
        for (int i = 0; i <= VALUE_DEPTH; i++)
            send_value(i);
        send_eol();
        for (int i = 0; i <= OPERATOR_DEPTH; i++)
            send_op(OP_OPEN);
        send_eol();
        wait_drained();
    endtask

    task automatic test_random(int tokens);
        int start;
        start = token_count;
        while (token_count - start < tokens)
        begin
            if ($urandom_range(9) < 8)
                send_expr(3);
            else
                repeat ($urandom_range(1, 5))
                    send_token(2'($urandom_range(1) ? $urandom_range(3) : 0),
                               rand_number(), 3'($urandom));
            send_eol();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (6)
            begin
                send_value(rand_number()); send_op(OP_ADD);
                send_value(rand_number()); send_eol();
            end
        join
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        calc_vcnt = 0;
        calc_ocnt = 0;
        calc_err  = ST_OK;
        error_count = 0;
        line_count  = 0;
        token_count = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_off  = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        test_random(350);
        idle_pct = 70;
        test_random(300);
        idle_pct  = 0;
        stall_pct = 70;
        test_random(300);
        idle_pct  = 13;
        stall_pct = 13;
        test_random(300);
        test_backpressure();

        $display("covered %0d tokens and %0d lines: precedence, parentheses, errors,",
                 token_count, line_count);
        $display("overflow, ignored tokens, idle and stall phases, long receiver hold-off");
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_ram.sv
rtl/iee_divider.sv
rtl/infix_expression_evaluator_unit.sv
rtl/iee_checker.sv
dv/tb_top.sv
